// File: rtl/spoe_pkg.sv
package spoe_pkg;

  // Command field of an input word
  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } spoe_cmd_t;

  // Status field of a result word
  typedef enum logic [1:0] {
    STAT_GRANT   = 2'd0,
    STAT_EVICT   = 2'd1,
    STAT_RELEASE = 2'd2,
    STAT_IGNORE  = 2'd3
  } spoe_status_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_APPLY = 3'b100
  } spoe_state_t;

  // Update command broadcast to every age cell
  typedef struct packed {
    logic apply;   // update the list this cycle
    logic append;  // 1: write new tag at pos, 0: shift toward head from pos on
  } spoe_cell_ctrl_t;

  localparam int unsigned GROUP_SIZE = 16;

endpackage

// File: rtl/slot_pool_oldest_eviction_core.sv
// Slot pool with oldest-first eviction.
// Input channel (in_valid/in_ready): one word per command. in_command
// allocates a slot (lowest free one) or releases in_slot_index.
// Result channel (out_valid/out_ready): exactly one word per command with
// out_status (granted, evicted and granted, released, release ignored) and
// out_granted_slot (low 4 bits of the slot number).
// Timing: an accepted word is scanned in the next cycle, and its result is
// registered when its apply state completes, which raises out_valid.
// Each word has a scan step (free-slot search and list match) and an apply
// step that updates the age cells; a new word is taken as that apply ends.
// The age list is a row of cells, oldest in cell 0; on a removal the cells
// from its position on shift from their younger neighbors in the same cycle.
// When the receiver stalls, the result word holds in the output register;
// the next word is still accepted and scanned, and waits in its apply cycle
// until the output register frees up.
// Reset (synchronous, rst_n low) empties the list and frees every slot;
// no clearing pass is needed, the block is ready right after reset.
module slot_pool_oldest_eviction_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [3:0] in_slot_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [3:0] out_granted_slot
);
  import spoe_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned TW = $clog2(SLOTS + 1);
  localparam int unsigned XW = (SW > 4) ? SW : 4;

  // sequencer
  spoe_state_t state_r, state_nxt;
  logic        apply_go;

  // accepted word
  logic       cmd_r;
  logic [3:0] idx_r;
  logic [XW-1:0] idx_x;

  // scan results
  logic [SLOTS-1:0] match;
  logic [SW-1:0]    mpos;
  logic [SW-1:0]    mpos_r;
  logic             rel_ok_r;

  // pool state
  logic [SLOTS-1:0] busy_r, busy_nxt;
  logic [TW-1:0]    len_r, len_nxt;
  logic [TW-1:0]    tags [SLOTS];

  // free-slot finder
  logic          free_found;
  logic [SW-1:0] free_slot;

  // apply decisions
  spoe_cell_ctrl_t ctrl;
  logic [TW-1:0]   cell_pos;
  logic [TW-1:0]   new_tag;
  logic [TW-1:0]   tail_tag;
  logic [TW-1:0]   probe;
  logic [SW-1:0]   head_slot;
  logic [SW-1:0]   sel_slot;
  logic [XW-1:0]   sel_slot_x;
  spoe_status_t    status;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r;
  logic [3:0] out_slot_r;

  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) || apply_go;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  state_nxt = S_APPLY;
      S_APPLY: if (apply_go) state_nxt = in_valid ? S_SCAN : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // latch the word on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      idx_r <= in_slot_index;
    end
  end

  assign idx_x = XW'(idx_r);
  assign probe = TW'(idx_x) + TW'(1);

  // encode the matching cell position (at most one cell matches)
  always_comb begin
    mpos = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (match[k]) mpos = mpos | SW'(k);
    end
  end

  // hold scan results for the apply cycle
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN) begin
      mpos_r   <= mpos;
      rel_ok_r <= (int'(idx_r) < SLOTS) && (|match);
    end
  end

  spoe_free_finder #(
    .SLOTS(SLOTS)
  ) u_free (
    .clk   (clk),
    .busy  (busy_r),
    .load  (state_r == S_SCAN),
    .found (free_found),
    .slot  (free_slot)
  );

  // oldest entry; an empty head falls back to slot 0
  assign head_slot = (tags[0] == '0) ? '0 : SW'(tags[0] - TW'(1));

  always_comb begin
    ctrl.apply  = 1'b0;
    ctrl.append = 1'b0;
    cell_pos    = '0;
    sel_slot    = '0;
    status      = STAT_IGNORE;
    busy_nxt    = busy_r;
    len_nxt     = len_r;
    if (cmd_r == CMD_ALLOC) begin
      if (free_found) begin
        // grant lowest free slot, append as newest
        ctrl.apply  = apply_go;
        ctrl.append = 1'b1;
        cell_pos    = len_r;
        sel_slot    = free_slot;
        status      = STAT_GRANT;
        if (apply_go) begin
          busy_nxt[free_slot] = 1'b1;
          len_nxt             = len_r + TW'(1);
        end
      end else begin
        // pool full: rotate the oldest to the tail
        ctrl.apply = apply_go;
        sel_slot   = head_slot;
        status     = STAT_EVICT;
        if (apply_go) busy_nxt[head_slot] = 1'b1;
      end
    end else if (rel_ok_r) begin
      // drop the entry and close the gap
      ctrl.apply = apply_go;
      cell_pos   = TW'(mpos_r);
      sel_slot   = idx_x[SW-1:0];
      status     = STAT_RELEASE;
      if (apply_go) begin
        busy_nxt[idx_x[SW-1:0]] = 1'b0;
        len_nxt                 = len_r - TW'(1);
      end
    end
  end

  assign new_tag    = TW'(sel_slot) + TW'(1);
  assign tail_tag   = (status == STAT_EVICT) ? new_tag : '0;
  assign sel_slot_x = XW'(sel_slot);

  // age list: cell 0 is the oldest, each cell feeds from its younger neighbor
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    logic [TW-1:0] nb_tag;
    if (k == SLOTS - 1) begin : g_tail
      assign nb_tag = tail_tag;
    end else begin : g_mid
      assign nb_tag = tags[k+1];
    end
    spoe_age_cell #(
      .IDX(k),
      .TW (TW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .pos      (cell_pos),
      .new_tag  (new_tag),
      .next_tag (nb_tag),
      .probe    (probe),
      .tag      (tags[k]),
      .match    (match[k])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (apply_go)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_status_r <= status;
      out_slot_r   <= (status == STAT_IGNORE) ? idx_r : sel_slot_x[3:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_slot = out_slot_r;

`ifndef NO_ASSERTIONS
  // fill count tracks the busy set
  a_len_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy_r) == int'(len_r))
    else $error("fill count differs from busy slot count");

  // eviction only with every slot taken
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    apply_go && (status == STAT_EVICT) |-> int'(len_r) == SLOTS)
    else $error("eviction with free slots left");

  // empty head means empty list
  a_head_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (tags[0] == '0) |-> (len_r == '0))
    else $error("age list not packed");

  // a scan is always followed by its apply cycle
  a_scan_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (state_r == S_APPLY))
    else $error("scan not followed by apply");
`endif

endmodule

// File: rtl/spoe_age_cell.sv
module spoe_age_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned TW  = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spoe_pkg::spoe_cell_ctrl_t ctrl,
  input  logic [TW-1:0]             pos,
  input  logic [TW-1:0]             new_tag,
  input  logic [TW-1:0]             next_tag,
  input  logic [TW-1:0]             probe,
  output logic [TW-1:0]             tag,
  output logic                      match
);
  import spoe_pkg::*;

  localparam logic [TW-1:0] MY_POS = TW'(IDX);

  logic [TW-1:0] tag_r;
  logic [TW-1:0] tag_nxt;

  always_comb begin
    tag_nxt = tag_r;
    if (ctrl.apply) begin
      if (ctrl.append) begin
        if (MY_POS == pos) tag_nxt = new_tag;
      end else if (MY_POS >= pos) begin
        // take the younger neighbor's entry to close the gap
        tag_nxt = next_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  assign tag   = tag_r;
  assign match = (tag_r == probe) && (tag_r != '0);

endmodule

// File: rtl/spoe_free_finder.sv
module spoe_free_finder #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                       clk,
  input  logic [SLOTS-1:0]           busy,
  input  logic                       load,
  output logic                       found,
  output logic [$clog2(SLOTS)-1:0]   slot
);
  import spoe_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned NG = (SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned OW = $clog2(GROUP_SIZE);

  logic [NG*GROUP_SIZE-1:0] busy_pad;
  logic [NG-1:0]            gfree;
  logic [OW-1:0]            goff [NG];
  logic [NG-1:0]            gfree_r;
  logic [OW-1:0]            goff_r [NG];
  logic [GW-1:0]            grp;
  logic [OW-1:0]            off;

  // pad missing slots as busy
  for (genvar i = 0; i < NG * GROUP_SIZE; i++) begin : g_pad
    if (i < SLOTS) begin : g_real
      assign busy_pad[i] = busy[i];
    end else begin : g_fill
      assign busy_pad[i] = 1'b1;
    end
  end

  // first level: lowest free slot inside each group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gfree[g] = ~&busy_pad[g*GROUP_SIZE +: GROUP_SIZE];
      goff[g]  = '0;
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
        if (!busy_pad[g*GROUP_SIZE + j]) goff[g] = OW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gfree_r <= gfree;
      for (int g = 0; g < NG; g++) goff_r[g] <= goff[g];
    end
  end

  // second level: lowest group with a free slot
  always_comb begin
    grp = '0;
    off = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (gfree_r[g]) begin
        grp = GW'(g);
        off = goff_r[g];
      end
    end
  end

  assign found = |gfree_r;
  assign slot  = SW'({grp, off});

endmodule
